FILE: design/vgdc_pkg.sv
package vgdc_pkg;

   localparam logic [1:0] GEAR_PARK    = 2'd0;
   localparam logic [1:0] GEAR_REVERSE = 2'd1;
   localparam logic [1:0] GEAR_NEUTRAL = 2'd2;
   localparam logic [1:0] GEAR_DRIVE   = 2'd3;

   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_STEP_UP   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_STEP_DOWN = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_BRAKING     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BRAKE_CUT       = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PARKING_BRAKING = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MIN_SPEED       = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_STEERING_LIMIT  = 3'd7;

   localparam int PEDAL_W  = 11;
   localparam int Q_FRAC   = 10;
   localparam int PROD_W   = PEDAL_W + 16;
   localparam int SCALED_W = PROD_W + 1 - Q_FRAC;

   localparam logic signed [15:0] PARK_SPEED_LIMIT = 16'sd10;

   localparam int STEER_IN_MAX = 4500;
   localparam int STEER_DIV    = 2 * STEER_IN_MAX;
   localparam int LIMIT_W      = 15;
   localparam int MAG_W        = $clog2(STEER_IN_MAX + 1);
   localparam int NUM_W        = MAG_W + 16;
   localparam int REC_K        = NUM_W + 1;
   localparam logic [63:0] REC_M = (64'd1 << REC_K) / STEER_DIV;
   localparam int REC_W        = $clog2(REC_M + 64'd1);
   localparam int REC_PW       = NUM_W + REC_W;

   localparam logic signed [15:0] STEER_MAX_S = 16'(STEER_IN_MAX);

   typedef struct packed {
      logic [15:0]        max_speed;
      logic [15:0]        speed_step_up;
      logic [15:0]        speed_step_down;
      logic [15:0]        max_braking;
      logic [15:0]        brake_cut_threshold;
      logic [15:0]        parking_braking;
      logic [15:0]        min_speed;
      logic [LIMIT_W-1:0] steering_limit;
   } cfg_type;

   typedef struct packed {
      logic gear_up;
      logic gear_down;
      logic neutral_button;
      logic park_button;
   } buttons_type;

   typedef struct packed {
      logic [1:0]  gear;
      logic        parking_brake;
      logic [15:0] braking;
      logic [15:0] speed;
   } drive_type;

endpackage

FILE: design/vehicle_gear_and_drive_controller.sv
// Gear and drive controller. Each control item on the req stream carries the buttons,
// lights, pedals, steering angle and measured speed; one result item per control item
// comes back on the rsp stream with the outputs for the gear that was active, and the
// gear for the next item is chosen at the same time. The block takes one item every
// clock cycle while the rsp side takes results; each item passes an input register, a
// stage of pedal and steering products, a stage that applies the gear and speed state
// and starts the steering divide, and the result register. A stalled rsp side holds
// items in those stages, so req_tready drops only once all four are full. The user must
// write registers through the csr port while no items are in flight; the block itself does not enforce this.
module vehicle_gear_and_drive_controller (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_tvalid,
   output logic                            req_tready,
   // gear_up, gear_down, neutral_button, park_button, right_light_in, left_light_in,
   // front_light_in, steering_angle[15:0], throttle[10:0], brake_pedal[10:0],
   // measured_speed[15:0], zero fill
   input  logic [63:0]                     req_tdata,

   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // gear_out[1:0], parking_brake, braking_cmd[15:0], speed_cmd[15:0],
   // steering_cmd[15:0], right_light_out, left_light_out, front_light_out, zero fill
   output logic [55:0]                     rsp_tdata,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vgdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int NW = vgdc_pkg::NUM_W;
   localparam int QW = vgdc_pkg::LIMIT_W;
   localparam int PW = vgdc_pkg::PROD_W;
   localparam logic [NW-1:0] DIV_N  = NW'(vgdc_pkg::STEER_DIV);
   localparam logic [NW-1:0] HALF_N = NW'(vgdc_pkg::STEER_IN_MAX);
   localparam logic [vgdc_pkg::REC_PW-1:0] REC_MUL =
      vgdc_pkg::REC_PW'(vgdc_pkg::REC_M);

   vgdc_pkg::cfg_type cfg;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic ready1, ready2, ready3, ready_out;

   // input stage
   logic [60:0] s1_data_ff;

   vgdc_pkg::buttons_type s1_buttons;
   logic signed [15:0]    s1_angle, s1_sat;
   logic [15:0]           s1_mag_full;
   logic [vgdc_pkg::MAG_W-1:0] s1_mag;
   logic [PW-1:0]         s1_brake_prod, s1_throttle_prod;
   logic [NW-1:0]         s1_num;

   // product stage
   vgdc_pkg::buttons_type s2_buttons_ff;
   logic [2:0]            s2_lights_ff;
   logic signed [15:0]    s2_feedback_ff;
   logic [PW-1:0]         s2_brake_prod_ff, s2_throttle_prod_ff;
   logic [NW-1:0]         s2_num_ff;
   logic                  s2_neg_ff;

   vgdc_pkg::drive_type           s2_drive;
   logic [vgdc_pkg::REC_PW-1:0]   s2_rec;

   // drive stage
   vgdc_pkg::drive_type s3_drive_ff;
   logic [2:0]          s3_lights_ff;
   logic [QW-1:0]       s3_qest_ff;
   logic [NW-1:0]       s3_num_ff;
   logic                s3_neg_ff;

   logic [NW-1:0] s3_rem;
   logic [QW-1:0] s3_quot;
   logic [15:0]   s3_steer;

   logic [55:0] rsp_data_ff;

   assign ready_out  = !out_valid_ff || rsp_tready;
   assign ready3     = !s3_valid_ff || ready_out;
   assign ready2     = !s2_valid_ff || ready3;
   assign ready1     = !s1_valid_ff || ready2;
   assign req_tready = ready1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;

   vgdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ready_out) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // input stage: pedal scaling products and steering numerator
   always_comb begin
      s1_buttons.gear_up        = s1_data_ff[0];
      s1_buttons.gear_down      = s1_data_ff[1];
      s1_buttons.neutral_button = s1_data_ff[2];
      s1_buttons.park_button    = s1_data_ff[3];
      s1_angle                  = s1_data_ff[22:7];

      if (s1_angle > vgdc_pkg::STEER_MAX_S) begin
         s1_sat = vgdc_pkg::STEER_MAX_S;
      end else if (s1_angle < -vgdc_pkg::STEER_MAX_S) begin
         s1_sat = -vgdc_pkg::STEER_MAX_S;
      end else begin
         s1_sat = s1_angle;
      end
      s1_mag_full = s1_angle[15] ? 16'(-s1_sat) : 16'(s1_sat);
      s1_mag      = s1_mag_full[vgdc_pkg::MAG_W-1:0];

      s1_brake_prod    = PW'(s1_data_ff[44:34]) * PW'(cfg.max_braking);
      s1_throttle_prod = PW'(s1_data_ff[33:23]) * PW'(cfg.max_speed);
      s1_num = ((NW'(s1_mag) * NW'(cfg.steering_limit)) << 1) + HALF_N;
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_tvalid) begin
         s1_data_ff <= req_tdata[60:0];
      end
      if (ready2 && s1_valid_ff) begin
         s2_buttons_ff       <= s1_buttons;
         s2_lights_ff        <= s1_data_ff[6:4];
         s2_feedback_ff      <= s1_data_ff[60:45];
         s2_brake_prod_ff    <= s1_brake_prod;
         s2_throttle_prod_ff <= s1_throttle_prod;
         s2_num_ff           <= s1_num;
         s2_neg_ff           <= s1_angle[15];
      end
   end

   // product stage: gear and speed state, reciprocal estimate of the steering quotient
   vgdc_drive u_drive (
      .clock          (clock),
      .reset          (reset),
      .advance        (s2_valid_ff && ready3),
      .cfg            (cfg),
      .buttons        (s2_buttons_ff),
      .measured_speed (s2_feedback_ff),
      .brake_prod     (s2_brake_prod_ff),
      .throttle_prod  (s2_throttle_prod_ff),
      .drive          (s2_drive)
   );

   assign s2_rec = vgdc_pkg::REC_PW'(s2_num_ff) * REC_MUL;

   always_ff @(posedge clock) begin
      if (ready3 && s2_valid_ff) begin
         s3_drive_ff  <= s2_drive;
         s3_lights_ff <= s2_lights_ff;
         s3_qest_ff   <= s2_rec[vgdc_pkg::REC_K +: QW];
         s3_num_ff    <= s2_num_ff;
         s3_neg_ff    <= s2_neg_ff;
      end
   end

   // drive stage: quotient correction and sign
   always_comb begin
      s3_rem   = s3_num_ff - NW'(s3_qest_ff) * DIV_N;
      s3_quot  = s3_qest_ff + QW'(s3_rem >= DIV_N);
      s3_steer = s3_neg_ff ? 16'(-{1'b0, s3_quot}) : 16'({1'b0, s3_quot});
   end

   always_ff @(posedge clock) begin
      if (ready_out && s3_valid_ff) begin
         rsp_data_ff <= {2'b00, s3_lights_ff[2], s3_lights_ff[1], s3_lights_ff[0],
                         s3_steer, s3_drive_ff.speed, s3_drive_ff.braking,
                         s3_drive_ff.parking_brake, s3_drive_ff.gear};
      end
   end

endmodule

FILE: design/vgdc_csr.sv
module vgdc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [vgdc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output vgdc_pkg::cfg_type               cfg
);

   vgdc_pkg::cfg_type cfg_ff;
   logic [vgdc_pkg::REG_IDX_W-1:0] index;
   logic write_en;

   assign index    = paddr[vgdc_pkg::CSR_ADDR_W-1:2];
   assign write_en = psel && penable && pwrite;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed           <= 16'd1000;
         cfg_ff.speed_step_up       <= 16'd10;
         cfg_ff.speed_step_down     <= 16'd20;
         cfg_ff.max_braking         <= 16'd1000;
         cfg_ff.brake_cut_threshold <= 16'd0;
         cfg_ff.parking_braking     <= 16'd1000;
         cfg_ff.min_speed           <= 16'd0;
         cfg_ff.steering_limit      <= vgdc_pkg::LIMIT_W'(1000);
      end else if (write_en) begin
         unique case (index)
            vgdc_pkg::REG_MAX_SPEED:       cfg_ff.max_speed <= pwdata[15:0];
            vgdc_pkg::REG_SPEED_STEP_UP:   cfg_ff.speed_step_up <= pwdata[15:0];
            vgdc_pkg::REG_SPEED_STEP_DOWN: cfg_ff.speed_step_down <= pwdata[15:0];
            vgdc_pkg::REG_MAX_BRAKING:     cfg_ff.max_braking <= pwdata[15:0];
            vgdc_pkg::REG_BRAKE_CUT:       cfg_ff.brake_cut_threshold <= pwdata[15:0];
            vgdc_pkg::REG_PARKING_BRAKING: cfg_ff.parking_braking <= pwdata[15:0];
            vgdc_pkg::REG_MIN_SPEED:       cfg_ff.min_speed <= pwdata[15:0];
            vgdc_pkg::REG_STEERING_LIMIT: begin
               cfg_ff.steering_limit <= pwdata[vgdc_pkg::LIMIT_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      unique case (index)
         vgdc_pkg::REG_MAX_SPEED:       prdata = {16'd0, cfg_ff.max_speed};
         vgdc_pkg::REG_SPEED_STEP_UP:   prdata = {16'd0, cfg_ff.speed_step_up};
         vgdc_pkg::REG_SPEED_STEP_DOWN: prdata = {16'd0, cfg_ff.speed_step_down};
         vgdc_pkg::REG_MAX_BRAKING:     prdata = {16'd0, cfg_ff.max_braking};
         vgdc_pkg::REG_BRAKE_CUT:       prdata = {16'd0, cfg_ff.brake_cut_threshold};
         vgdc_pkg::REG_PARKING_BRAKING: prdata = {16'd0, cfg_ff.parking_braking};
         vgdc_pkg::REG_MIN_SPEED:       prdata = {16'd0, cfg_ff.min_speed};
         vgdc_pkg::REG_STEERING_LIMIT:  prdata = 32'(cfg_ff.steering_limit);
         default:                       prdata = 32'd0;
      endcase
   end

endmodule

FILE: design/vgdc_drive.sv
module vgdc_drive (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  vgdc_pkg::cfg_type             cfg,
   input  vgdc_pkg::buttons_type         buttons,
   input  logic signed [15:0]            measured_speed,
   input  logic [vgdc_pkg::PROD_W-1:0]   brake_prod,
   input  logic [vgdc_pkg::PROD_W-1:0]   throttle_prod,
   output vgdc_pkg::drive_type           drive
);

   localparam int SW = vgdc_pkg::SCALED_W;
   localparam logic [vgdc_pkg::PROD_W:0] ROUND_HALF =
      (vgdc_pkg::PROD_W + 1)'(1) << (vgdc_pkg::Q_FRAC - 1);

   logic [1:0]  gear_ff, gear_in;
   logic [15:0] speed_ff, speed_in;

   logic [vgdc_pkg::PROD_W:0] brake_round, throttle_round;
   logic [SW-1:0] brake_scaled, target, current, diff, step, slew;
   logic [SW-1:0] max_speed_w, max_braking_w;
   logic [15:0]   braking, slew_clamped;
   logic          park_ok, cut;

   always_comb begin
      brake_round    = {1'b0, brake_prod} + ROUND_HALF;
      throttle_round = {1'b0, throttle_prod} + ROUND_HALF;
      brake_scaled   = brake_round[vgdc_pkg::PROD_W:vgdc_pkg::Q_FRAC];
      target         = throttle_round[vgdc_pkg::PROD_W:vgdc_pkg::Q_FRAC];
      max_speed_w    = SW'(cfg.max_speed);
      max_braking_w  = SW'(cfg.max_braking);
      current        = SW'(speed_ff);

      braking = (brake_scaled > max_braking_w) ? cfg.max_braking : brake_scaled[15:0];
      cut     = braking > cfg.brake_cut_threshold;

      if (target > current) begin
         diff = target - current;
         step = (diff < SW'(cfg.speed_step_up)) ? diff : SW'(cfg.speed_step_up);
         slew = current + step;
      end else begin
         diff = current - target;
         step = (diff < SW'(cfg.speed_step_down)) ? diff : SW'(cfg.speed_step_down);
         slew = current - step;
      end
      slew_clamped = (slew > max_speed_w) ? cfg.max_speed : slew[15:0];

      park_ok = (measured_speed < vgdc_pkg::PARK_SPEED_LIMIT) &&
                (measured_speed > -vgdc_pkg::PARK_SPEED_LIMIT);

      drive.gear          = gear_ff;
      drive.parking_brake = 1'b0;
      drive.braking       = braking;
      drive.speed         = speed_ff;
      gear_in             = gear_ff;
      speed_in            = speed_ff;

      unique case (gear_ff)
         vgdc_pkg::GEAR_PARK: begin
            drive.parking_brake = 1'b1;
            drive.braking       = cfg.parking_braking;
            drive.speed         = cfg.min_speed;
            speed_in            = cfg.min_speed;
            if (buttons.gear_up) begin
               gear_in = vgdc_pkg::GEAR_REVERSE;
            end else if (buttons.neutral_button) begin
               gear_in = vgdc_pkg::GEAR_NEUTRAL;
            end
         end
         vgdc_pkg::GEAR_NEUTRAL: begin
            if (buttons.gear_up) begin
               gear_in = vgdc_pkg::GEAR_DRIVE;
            end else if (buttons.gear_down) begin
               gear_in = vgdc_pkg::GEAR_REVERSE;
            end else if (buttons.park_button && park_ok) begin
               gear_in = vgdc_pkg::GEAR_PARK;
            end
         end
         vgdc_pkg::GEAR_REVERSE: begin
            drive.speed = cut ? cfg.min_speed : slew_clamped;
            speed_in    = drive.speed;
            if (buttons.gear_up || buttons.neutral_button) begin
               gear_in = vgdc_pkg::GEAR_NEUTRAL;
            end else if ((buttons.gear_down || buttons.park_button) && park_ok) begin
               gear_in = vgdc_pkg::GEAR_PARK;
            end
         end
         vgdc_pkg::GEAR_DRIVE: begin
            drive.speed = cut ? cfg.min_speed : slew_clamped;
            speed_in    = drive.speed;
            if (buttons.gear_down || buttons.neutral_button) begin
               gear_in = vgdc_pkg::GEAR_NEUTRAL;
            end else if (buttons.park_button && park_ok) begin
               gear_in = vgdc_pkg::GEAR_PARK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff  <= vgdc_pkg::GEAR_PARK;
         speed_ff <= 16'd0;
      end else if (advance) begin
         gear_ff  <= gear_in;
         speed_ff <= speed_in;
      end
   end

endmodule
